/* rtl/rssc_pkg.sv */
// Package for the rotated/scaled sprite sampler: payload and command types,
// configuration register map and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rssc_pkg;

  localparam int unsigned TexelDepthDefault = 65536;
  localparam int unsigned CoordBitsDefault  = 11;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned ColorW  = 24;
  localparam int unsigned DestW   = 11;
  localparam int unsigned StepPW  = DestW + 1;
  localparam int unsigned StepW   = 22;
  localparam int unsigned StartW  = 28;
  localparam int unsigned SizeW   = 9;
  localparam int unsigned ProdW   = StepPW + 1 + StepW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned QueuePtrW = 2;
  localparam int unsigned QueueDepth = 1 << QueuePtrW;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_RENDER = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_COS      = 4'd0,
    REG_STEP_SIN      = 4'd1,
    REG_START_U       = 4'd2,
    REG_START_V       = 4'd3,
    REG_SPRITE_WIDTH  = 4'd4,
    REG_SPRITE_HEIGHT = 4'd5,
    REG_MIRROR_ENABLE = 4'd6,
    REG_ONLY_ON_BLACK = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic              func;
    logic [AddrW-1:0]  texel_addr;
    logic [ColorW-1:0] texel_color;
    logic [DestW-1:0]  dest_h;
    logic [DestW-1:0]  dest_v;
    logic              dest_is_black;
  } in_item_t;

  typedef struct packed {
    logic              draw;
    logic [DestW-1:0]  out_h;
    logic [DestW-1:0]  out_v;
    logic [ColorW-1:0] pixel_color;
  } out_item_t;

  typedef struct packed {
    logic signed [StepW-1:0]  step_cos;
    logic signed [StepW-1:0]  step_sin;
    logic signed [StartW-1:0] start_u;
    logic signed [StartW-1:0] start_v;
    logic [SizeW-1:0]         sprite_width;
    logic [SizeW-1:0]         sprite_height;
    logic                     mirror_enable;
    logic                     only_on_black;
  } cfg_t;

  typedef struct packed {
    logic              render;
    logic [AddrW-1:0]  texel_addr;
    logic [ColorW-1:0] texel_color;
    logic [DestW-1:0]  dest_h;
    logic [DestW-1:0]  dest_v;
    logic [StepPW-1:0] hp;
    logic [StepPW-1:0] vp;
    logic              black;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/rssc_front.sv */
// Front end: configuration registers, input transaction register and command
// classification (write vs render, masked and stepped coordinates). Uses rssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rssc_front #(
  parameter int unsigned COORD_BITS = rssc_pkg::CoordBitsDefault
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire rssc_pkg::in_item_t       in_data_i,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [rssc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [rssc_pkg::CfgDataW-1:0]  cfg_data_i,
  output rssc_pkg::cfg_t                cfg_o,
  output logic                          cmd_valid_o,
  input  wire                           cmd_ready_i,
  output rssc_pkg::cmd_t                cmd_o
);
  import rssc_pkg::*;

  localparam logic [DestW-1:0] CoordMask =
    (COORD_BITS >= DestW) ? {DestW{1'b1}} : DestW'((1 << COORD_BITS) - 1);

  cfg_t cfg_q;
  logic vld_q;
  cmd_t cmd_q, cmd_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;
  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_cos      <= StepW'(65536);
      cfg_q.step_sin      <= '0;
      cfg_q.start_u       <= '0;
      cfg_q.start_v       <= '0;
      cfg_q.sprite_width  <= SizeW'(256);
      cfg_q.sprite_height <= SizeW'(256);
      cfg_q.mirror_enable <= 1'b0;
      cfg_q.only_on_black <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_STEP_COS:      cfg_q.step_cos      <= cfg_data_i[StepW-1:0];
        REG_STEP_SIN:      cfg_q.step_sin      <= cfg_data_i[StepW-1:0];
        REG_START_U:       cfg_q.start_u       <= cfg_data_i[StartW-1:0];
        REG_START_V:       cfg_q.start_v       <= cfg_data_i[StartW-1:0];
        REG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_data_i[SizeW-1:0];
        REG_SPRITE_HEIGHT: cfg_q.sprite_height <= cfg_data_i[SizeW-1:0];
        REG_MIRROR_ENABLE: cfg_q.mirror_enable <= cfg_data_i[0];
        REG_ONLY_ON_BLACK: cfg_q.only_on_black <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd_d.render      = (in_data_i.func == FUNC_RENDER);
    cmd_d.texel_addr  = in_data_i.texel_addr;
    cmd_d.texel_color = in_data_i.texel_color;
    cmd_d.dest_h      = in_data_i.dest_h;
    cmd_d.dest_v      = in_data_i.dest_v;
    cmd_d.hp          = StepPW'(in_data_i.dest_h & CoordMask) + StepPW'(1);
    cmd_d.vp          = StepPW'(in_data_i.dest_v & CoordMask) + StepPW'(1);
    cmd_d.black       = in_data_i.dest_is_black;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/rssc_queue.sv */
// Short command queue between front and back end.
// Uses rssc_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rssc_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_valid_i,
  output logic                 push_ready_o,
  input  wire rssc_pkg::cmd_t  push_data_i,
  output logic                 pop_valid_o,
  input  wire                  pop_ready_i,
  output rssc_pkg::cmd_t       pop_data_o
);
  import rssc_pkg::*;

  localparam int unsigned CntW = QueuePtrW + 1;

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/rssc_back.sv */
// Back end: coordinate pipeline (products, sums, bounds test, address),
// texel store and output register. Uses rssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rssc_back #(
  parameter int unsigned TEXEL_DEPTH = rssc_pkg::TexelDepthDefault
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire rssc_pkg::cfg_t  cfg_i,
  input  wire                  cmd_valid_i,
  output logic                 cmd_ready_o,
  input  wire rssc_pkg::cmd_t  cmd_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output rssc_pkg::out_item_t  out_data_o
);
  import rssc_pkg::*;

  // the user must keep store depth a power of two; this block does not enforce it; addresses wrap on the low bits
  localparam int unsigned TAW  = $clog2(TEXEL_DEPTH);
  localparam int unsigned RdW  = 2 * SizeW;
  localparam int unsigned ExtW = (TAW > RdW) ? TAW : RdW;

  logic [ColorW-1:0] store_q [TEXEL_DEPTH];

  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic out_free, s4_free, s3_free, s2_free, s1_free;

  cmd_t s1_cmd_q, s2_cmd_q, s3_cmd_q, s4_cmd_q;
  logic signed [ProdW-1:0] pch_q, psh_q, pcv_q, psv_q;
  logic signed [SumW-1:0]  u_q, w_q;
  logic signed [SumW-1:0]  u_d, w_d;

  logic [SumW-FracW-1:0] col_w, row_w;
  logic [SizeW-1:0]      col_d, mcol_d;
  logic                  hit_d;
  logic                  hit3_q, hit4_q;
  logic [SizeW-1:0]      col3_q, row3_q;
  logic [ExtW-1:0]       raddr_ext, waddr_ext;
  logic [TAW-1:0]        addr4_q;

  logic                  draw_q;
  logic [DestW-1:0]      oh_q, ov_q;
  logic [ColorW-1:0]     rdata_q;

  assign out_free    = !out_vld_q || out_ready_i;
  assign s4_free     = !s4_vld_q || out_free;
  assign s3_free     = !s3_vld_q || s4_free;
  assign s2_free     = !s2_vld_q || s3_free;
  assign s1_free     = !s1_vld_q || s2_free;
  assign cmd_ready_o = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_free)  s1_vld_q  <= cmd_valid_i;
      if (s2_free)  s2_vld_q  <= s1_vld_q;
      if (s3_free)  s3_vld_q  <= s2_vld_q;
      if (s4_free)  s4_vld_q  <= s3_vld_q;
      if (out_free) out_vld_q <= s4_vld_q && s4_cmd_q.render;
    end
  end

  // stage 1: four products
  always_ff @(posedge clk_i) begin
    if (s1_free && cmd_valid_i) begin
      s1_cmd_q <= cmd_i;
      pch_q <= $signed({1'b0, cmd_i.hp}) * $signed(cfg_i.step_cos);
      psh_q <= $signed({1'b0, cmd_i.hp}) * $signed(cfg_i.step_sin);
      pcv_q <= $signed({1'b0, cmd_i.vp}) * $signed(cfg_i.step_cos);
      psv_q <= $signed({1'b0, cmd_i.vp}) * $signed(cfg_i.step_sin);
    end
  end

  // stage 2: source coordinates
  assign u_d = SumW'($signed(cfg_i.start_u)) + SumW'(pch_q) + SumW'(psv_q);
  assign w_d = SumW'($signed(cfg_i.start_v)) + SumW'(pcv_q) - SumW'(psh_q);

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_vld_q) begin
      s2_cmd_q <= s1_cmd_q;
      u_q      <= u_d;
      w_q      <= w_d;
    end
  end

  // stage 3: bounds and mode test, mirroring
  assign col_w = u_q[SumW-1:FracW];
  assign row_w = w_q[SumW-1:FracW];
  assign col_d = u_q[FracW+SizeW-1:FracW];
  assign hit_d = !u_q[SumW-1] && !w_q[SumW-1]
              && (!cfg_i.only_on_black || s2_cmd_q.black)
              && (col_w < (SumW-FracW)'(cfg_i.sprite_width))
              && (row_w < (SumW-FracW)'(cfg_i.sprite_height));
  assign mcol_d = cfg_i.mirror_enable ? (cfg_i.sprite_width - SizeW'(1) - col_d) : col_d;

  always_ff @(posedge clk_i) begin
    if (s3_free && s2_vld_q) begin
      s3_cmd_q <= s2_cmd_q;
      hit3_q   <= hit_d;
      col3_q   <= mcol_d;
      row3_q   <= w_q[FracW+SizeW-1:FracW];
    end
  end

  // stage 4: store address
  assign raddr_ext = ExtW'(RdW'(col3_q) + RdW'(cfg_i.sprite_width) * RdW'(row3_q));
  assign waddr_ext = ExtW'(s3_cmd_q.texel_addr);

  always_ff @(posedge clk_i) begin
    if (s4_free && s3_vld_q) begin
      s4_cmd_q <= s3_cmd_q;
      hit4_q   <= hit3_q;
      addr4_q  <= s3_cmd_q.render ? raddr_ext[TAW-1:0] : waddr_ext[TAW-1:0];
    end
  end

  // texel store access and output register
  always_ff @(posedge clk_i) begin
    if (out_free && s4_vld_q) begin
      if (s4_cmd_q.render) begin
        rdata_q <= store_q[addr4_q];
        draw_q  <= hit4_q;
        oh_q    <= s4_cmd_q.dest_h;
        ov_q    <= s4_cmd_q.dest_v;
      end else begin
        store_q[addr4_q] <= s4_cmd_q.texel_color;
      end
    end
  end

  assign out_valid_o             = out_vld_q;
  assign out_data_o.draw         = draw_q;
  assign out_data_o.out_h        = oh_q;
  assign out_data_o.out_v        = ov_q;
  assign out_data_o.pixel_color  = draw_q ? rdata_q : '0;

endmodule

`default_nettype wire

/* rtl/rotated_scaled_sprite_sampler_core.sv */
// Top level of the rotated/scaled sprite sampler: front end, command queue
// and back end. Uses rssc_pkg, rssc_front, rssc_queue, rssc_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i): func 0 writes texel_color
//   to the texel store at texel_addr; func 1 renders destination pixel
//   (dest_h, dest_v) and yields exactly one output transaction.
//   Output channel (out_valid_o/out_ready_i/out_data_o): draw flag, echoed
//   coordinates and sampled color (zero when not drawn).
//   Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): always
//   ready; write only while no transactions are in flight.
//   A render result passes the input register, queue, back pipeline and output register.
//   Throughput: one transaction per cycle while the receiver does not stall,
//   set by the single-port texel store that serves one write or one read per cycle.
//   Reset clears control and loads register defaults; the texel store is not
//   cleared. When the receiver stalls, the back pipeline holds, then a 4-entry
//   queue and the input register fill before in_ready_o drops.
//   TEXEL_DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module rotated_scaled_sprite_sampler_core #(
  parameter int unsigned TEXEL_DEPTH = rssc_pkg::TexelDepthDefault,
  parameter int unsigned COORD_BITS  = rssc_pkg::CoordBitsDefault
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire rssc_pkg::in_item_t       in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output rssc_pkg::out_item_t           out_data_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [rssc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [rssc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rssc_pkg::*;

  cfg_t cfg;
  cmd_t fr_cmd, q_cmd;
  logic fr_valid, fr_ready, q_valid, q_ready;

  rssc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  rssc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  rssc_back #(
    .TEXEL_DEPTH(TEXEL_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/rssc_checker.sv */
// Port-level checker for the sprite sampler and its bind statement.
// Uses rssc_pkg; attaches to rotated_scaled_sprite_sampler_core.
`timescale 1ns / 1ps
`default_nettype none

module rssc_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       out_valid_o,
  input wire                       out_ready_i,
  input wire rssc_pkg::out_item_t  out_data_o,
  input wire                       cfg_ready_o
);
  import rssc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  a_color_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.draw |-> out_data_o.pixel_color == '0)
    else $error("nonzero color on undrawn pixel");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cfg_ready_o)
    else $error("config port not ready");

endmodule

bind rotated_scaled_sprite_sampler_core rssc_checker u_rssc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
